### sv/tlb_pkg.sv
// Package for the translation lookaside buffer: item kinds, result codes,
// page geometry and the structs passed between the TLB modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tlb_pkg;

	// Page geometry: 4 KiB pages on a 32-bit address.
	localparam int unsigned AddrWidth   = 32;
	localparam int unsigned PageShift   = 12;
	localparam int unsigned PageWidth   = AddrWidth - PageShift;
	localparam int unsigned IndexWidth  = 4;
	localparam int unsigned DefEntries  = 16;
	localparam logic [PageShift-1:0] OffsetMask = 12'hFFF;

	// Kinds of input item.
	typedef enum logic [1:0] {
		KIND_LOOKUP = 2'd0,
		KIND_FILL   = 2'd1,
		KIND_FLUSH  = 2'd2
	} kind_t;

	// Result codes.
	typedef enum logic [2:0] {
		ST_HIT   = 3'd0,
		ST_MISS  = 3'd1,
		ST_PROT  = 3'd2,
		ST_SAME  = 3'd3,
		ST_FREE  = 3'd4,
		ST_EVICT = 3'd5,
		ST_FLUSH = 3'd6
	} status_t;

	// One input item as held in the input register.
	typedef struct packed {
		logic [1:0]           kind;
		logic [AddrWidth-1:0] virt_addr;
		logic [AddrWidth-1:0] fill_phys_addr;
		logic                 access_write;
	} item_t;

	// One result item.
	typedef struct packed {
		logic [2:0]            status;
		logic [AddrWidth-1:0]  phys_addr;
		logic [IndexWidth-1:0] entry_index;
		logic [PageWidth-1:0]  old_page;
	} result_t;

	// Update command from the decision logic to the entry storage.
	typedef struct packed {
		logic                 write;      // write the selected entry
		logic                 keep_frame; // rewrite page and permission only
		logic                 flush;      // clear every valid bit
		logic                 advance;    // step the eviction pointer
		logic [PageWidth-1:0] page;
		logic [PageWidth-1:0] frame;
		logic                 writable;
	} update_t;

endpackage

`default_nettype wire

### sv/tlb_if.sv
// Valid/ready channel interfaces for the TLB request and result items.
// Depends on tlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface tlb_req_if;
	logic                           valid;
	logic                           ready;
	logic [1:0]                     kind;
	logic [tlb_pkg::AddrWidth-1:0]  virt_addr;
	logic [tlb_pkg::AddrWidth-1:0]  fill_phys_addr;
	logic                           access_write;

	modport source (output valid, kind, virt_addr, fill_phys_addr, access_write,
		input ready);
	modport sink (input valid, kind, virt_addr, fill_phys_addr, access_write,
		output ready);
endinterface

interface tlb_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [2:0]                     status;
	logic [tlb_pkg::AddrWidth-1:0]  phys_addr;
	logic [tlb_pkg::IndexWidth-1:0] entry_index;
	logic [tlb_pkg::PageWidth-1:0]  old_page;

	modport source (output valid, status, phys_addr, entry_index, old_page,
		input ready);
	modport sink (input valid, status, phys_addr, entry_index, old_page,
		output ready);
endinterface

`default_nettype wire

### sv/tlb_entries.sv
// Entry storage of the TLB: valid bits, page, frame and permission per
// entry, and the round-robin eviction pointer. Depends on tlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlb_entry_store #(
	parameter int unsigned ENTRIES = tlb_pkg::DefEntries,
	parameter int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           en,
	input  wire tlb_pkg::update_t               upd,
	input  wire logic [IW-1:0]                  upd_idx,
	output logic                                valid_q   [ENTRIES],
	output logic [tlb_pkg::PageWidth-1:0]       page_q    [ENTRIES],
	output logic [tlb_pkg::PageWidth-1:0]       frame_q   [ENTRIES],
	output logic                                writable_q[ENTRIES],
	output logic [IW-1:0]                       ptr_q
);

	localparam logic [IW-1:0] LastIdx = IW'(ENTRIES - 1);

	// Valid bits: set on any write, cleared by a flush.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ENTRIES; k++) valid_q[k] <= 1'b0;
		end else if (en) begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (upd.flush) begin
					valid_q[k] <= 1'b0;
				end else if (upd.write && (upd_idx == IW'(k))) begin
					valid_q[k] <= 1'b1;
				end
			end
		end
	end

	// Entry payload; a same-frame reuse leaves the frame as it is.
	always_ff @(posedge clk) begin
		if (en && upd.write) begin
			for (int k = 0; k < ENTRIES; k++) begin
				if (upd_idx == IW'(k)) begin
					page_q[k]     <= upd.page;
					writable_q[k] <= upd.writable;
					if (!upd.keep_frame) begin
						frame_q[k] <= upd.frame;
					end
				end
			end
		end
	end

	// Round-robin pointer moves only on eviction and wraps at the last entry.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ptr_q <= '0;
		end else if (en && upd.advance) begin
			ptr_q <= (ptr_q == LastIdx) ? '0 : ptr_q + 1'b1;
		end
	end

endmodule

`default_nettype wire

### sv/tlb_decide.sv
// Decision logic of the TLB: parallel page and frame compares, lowest-index
// selection, the result item and the update command. Depends on tlb_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tlb_decide #(
	parameter int unsigned ENTRIES = tlb_pkg::DefEntries,
	parameter int unsigned IW      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
	input  wire tlb_pkg::item_t                 item,
	input  wire logic                           valid_q   [ENTRIES],
	input  wire logic [tlb_pkg::PageWidth-1:0]  page_q    [ENTRIES],
	input  wire logic [tlb_pkg::PageWidth-1:0]  frame_q   [ENTRIES],
	input  wire logic                           writable_q[ENTRIES],
	input  wire logic [IW-1:0]                  ptr_q,
	output tlb_pkg::result_t                    res,
	output tlb_pkg::update_t                    upd,
	output logic [IW-1:0]                       upd_idx
);

	localparam int unsigned PW = tlb_pkg::PageWidth;
	localparam int unsigned PS = tlb_pkg::PageShift;

	logic [PW-1:0]      page;
	logic [PW-1:0]      frame;
	logic [ENTRIES-1:0] page_hit;
	logic [ENTRIES-1:0] frame_hit;
	logic [ENTRIES-1:0] free_vec;
	logic [ENTRIES-1:0] page_oh;
	logic [ENTRIES-1:0] frame_oh;
	logic [IW-1:0]      page_idx;
	logic [IW-1:0]      frame_idx;
	logic [IW-1:0]      free_idx;
	logic [PW-1:0]      hit_frame;
	logic               hit_writable;
	logic [PW-1:0]      same_old_page;
	logic [PW-1:0]      ptr_old_page;
	logic [31:0]        idx_wide;

	assign page  = item.virt_addr[tlb_pkg::AddrWidth-1:PS];
	assign frame = item.fill_phys_addr[tlb_pkg::AddrWidth-1:PS];

	// Compare every entry in parallel.
	always_comb begin
		for (int k = 0; k < ENTRIES; k++) begin
			page_hit[k]  = valid_q[k] && (page_q[k] == page);
			frame_hit[k] = valid_q[k] && (frame_q[k] == frame);
			free_vec[k]  = !valid_q[k];
		end
	end

	// Lowest set bit as a one-hot vector and as an index.
	assign page_oh  = page_hit & (~page_hit + 1'b1);
	assign frame_oh = frame_hit & (~frame_hit + 1'b1);

	always_comb begin
		page_idx  = '0;
		frame_idx = '0;
		free_idx  = '0;
		for (int k = ENTRIES - 1; k >= 0; k--) begin
			if (page_hit[k])  page_idx  = IW'(k);
			if (frame_hit[k]) frame_idx = IW'(k);
			if (free_vec[k])  free_idx  = IW'(k);
		end
	end

	// Read out the selected entries through and-or muxes.
	always_comb begin
		hit_frame     = '0;
		hit_writable  = 1'b0;
		same_old_page = '0;
		ptr_old_page  = '0;
		for (int k = 0; k < ENTRIES; k++) begin
			if (page_oh[k]) begin
				hit_frame    = hit_frame | frame_q[k];
				hit_writable = hit_writable | writable_q[k];
			end
			if (frame_oh[k]) same_old_page = same_old_page | page_q[k];
			if (ptr_q == IW'(k)) ptr_old_page = ptr_old_page | page_q[k];
		end
	end

	// Result and update for the item's kind.
	always_comb begin
		res            = '0;
		res.status     = tlb_pkg::ST_MISS;
		upd            = '0;
		upd.page       = page;
		upd.frame      = frame;
		upd.writable   = item.access_write;
		upd_idx        = '0;
		case (tlb_pkg::kind_t'(item.kind))
			tlb_pkg::KIND_LOOKUP: begin
				if (|page_hit) begin
					upd_idx = page_idx;
					if (!hit_writable && item.access_write) begin
						res.status = tlb_pkg::ST_PROT;
					end else begin
						res.status    = tlb_pkg::ST_HIT;
						res.phys_addr = {hit_frame, item.virt_addr[PS-1:0] & tlb_pkg::OffsetMask};
					end
				end
			end
			tlb_pkg::KIND_FILL: begin
				upd.write = 1'b1;
				if (|frame_hit) begin
					res.status     = tlb_pkg::ST_SAME;
					res.old_page   = same_old_page;
					upd_idx        = frame_idx;
					upd.keep_frame = 1'b1;
				end else if (|free_vec) begin
					res.status = tlb_pkg::ST_FREE;
					upd_idx    = free_idx;
				end else begin
					res.status   = tlb_pkg::ST_EVICT;
					res.old_page = ptr_old_page;
					upd_idx      = ptr_q;
					upd.advance  = 1'b1;
				end
			end
			tlb_pkg::KIND_FLUSH: begin
				res.status = tlb_pkg::ST_FLUSH;
				upd.flush  = 1'b1;
			end
			default: begin
				res.status = tlb_pkg::ST_MISS;
			end
		endcase
		// Miss and flush report entry zero.
		if (res.status == tlb_pkg::ST_MISS || res.status == tlb_pkg::ST_FLUSH) begin
			upd_idx = '0;
		end
		// The reported index is the low bits of the entry number.
		idx_wide        = 32'(upd_idx);
		res.entry_index = idx_wide[tlb_pkg::IndexWidth-1:0];
	end

endmodule

`default_nettype wire

### sv/tlb_lookup_and_fill.sv
// Top level of the fully associative TLB: input register, decision logic,
// entry storage and result register. Depends on tlb_pkg, tlb_if,
// tlb_entry_store and tlb_decide.
//
//   channel  direction  interface   payload
//   req      in         tlb_req_if  kind, virt_addr, fill_phys_addr, access_write
//   rsp      out        tlb_rsp_if  status, phys_addr, entry_index, old_page
//
// One item per cycle sustained while each result is taken as it is offered;
// an item goes through the input register, then compare and update into the
// result register, which offers its result. The entry update of one item
// lands at the edge that registers its result, so the next item already
// sees it.
// Reset clears the valid bits, the eviction pointer and both valid flags;
// no clearing pass is needed. A stalled result holds the input register,
// and the input register still takes an item while it is empty.
`timescale 1ns / 1ps
`default_nettype none

module tlb_lookup_and_fill #(
	parameter int unsigned ENTRIES = tlb_pkg::DefEntries
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	tlb_req_if.sink    req,
	tlb_rsp_if.source  rsp
);

	localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

	tlb_pkg::item_t   item_s1;
	logic             valid_s1;
	tlb_pkg::result_t res;
	tlb_pkg::result_t res_s2;
	logic             valid_s2;
	tlb_pkg::update_t upd;
	logic [IW-1:0]    upd_idx;
	logic             advance;

	logic                        valid_q   [ENTRIES];
	logic [tlb_pkg::PageWidth-1:0] page_q  [ENTRIES];
	logic [tlb_pkg::PageWidth-1:0] frame_q [ENTRIES];
	logic                        writable_q[ENTRIES];
	logic [IW-1:0]               ptr_q;

	// The held item moves on when the result register is free or being taken.
	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1.kind           <= req.kind;
			item_s1.virt_addr      <= req.virt_addr;
			item_s1.fill_phys_addr <= req.fill_phys_addr;
			item_s1.access_write   <= req.access_write;
		end
	end

	tlb_decide #(
		.ENTRIES (ENTRIES),
		.IW      (IW)
	) u_decide (
		.item       (item_s1),
		.valid_q    (valid_q),
		.page_q     (page_q),
		.frame_q    (frame_q),
		.writable_q (writable_q),
		.ptr_q      (ptr_q),
		.res        (res),
		.upd        (upd),
		.upd_idx    (upd_idx)
	);

	tlb_entry_store #(
		.ENTRIES (ENTRIES),
		.IW      (IW)
	) u_entries (
		.clk        (clk),
		.arst_n     (arst_n),
		.en         (advance),
		.upd        (upd),
		.upd_idx    (upd_idx),
		.valid_q    (valid_q),
		.page_q     (page_q),
		.frame_q    (frame_q),
		.writable_q (writable_q),
		.ptr_q      (ptr_q)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res;
		end
	end

	assign rsp.valid       = valid_s2;
	assign rsp.status      = res_s2.status;
	assign rsp.phys_addr   = res_s2.phys_addr;
	assign rsp.entry_index = res_s2.entry_index;
	assign rsp.old_page    = res_s2.old_page;

endmodule

`default_nettype wire

### sv/tlb_checker.sv
// Port-level checks on the TLB result channel, and the bind that attaches
// them to the top level. Depends on tlb_pkg and tlb_lookup_and_fill.
`timescale 1ns / 1ps
`default_nettype none

module tlb_checker (
	input wire logic                           clk,
	input wire logic                           arst_n,
	input wire logic                           rsp_valid,
	input wire logic                           rsp_ready,
	input wire logic [2:0]                     status,
	input wire logic [tlb_pkg::AddrWidth-1:0]  phys_addr,
	input wire logic [tlb_pkg::IndexWidth-1:0] entry_index,
	input wire logic [tlb_pkg::PageWidth-1:0]  old_page
);

	// A result that is not taken stays offered.
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result withdrawn before it was taken");

	// Only a hit carries a translated address.
	a_phys_only_on_hit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status != tlb_pkg::ST_HIT) |-> (phys_addr == '0))
		else $error("translated address on a result that is not a hit");

	// Miss and flush name no entry and no old page.
	a_idle_fields: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (status == tlb_pkg::ST_MISS || status == tlb_pkg::ST_FLUSH)
		|-> (entry_index == '0) && (old_page == '0))
		else $error("miss or flush reports an entry");

	// An old page comes only from a reuse or an eviction.
	a_old_page_src: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && (old_page != '0)
		|-> (status == tlb_pkg::ST_SAME || status == tlb_pkg::ST_EVICT))
		else $error("old page reported without a replacement");

endmodule

bind tlb_lookup_and_fill tlb_checker u_tlb_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.rsp_valid   (rsp.valid),
	.rsp_ready   (rsp.ready),
	.status      (rsp.status),
	.phys_addr   (rsp.phys_addr),
	.entry_index (rsp.entry_index),
	.old_page    (rsp.old_page)
);

`default_nettype wire
